// ===== rtl/labeled_relation_closure_unit_assert.svh =====
`ifndef LABELED_RELATION_CLOSURE_UNIT_ASSERT_SVH
`define LABELED_RELATION_CLOSURE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lrc_pkg.sv =====
`timescale 1ns / 1ps

package lrc_pkg;

	localparam int NUM_TYPES = 128;
	localparam int TYPE_W    = $clog2(NUM_TYPES);
	localparam int FIELD_W   = 7;
	localparam int LABEL_W   = 4;
	localparam int KIND_W    = 3;

	localparam logic [LABEL_W-1:0] EXACT_MASK = 4'h6;

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [TYPE_W-1:0] row_addr_t;
	typedef logic [NUM_TYPES-1:0][LABEL_W-1:0] row_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic      re;
		row_addr_t raddr;
		logic      we;
		row_addr_t waddr;
		row_t      wdata;
	} mem_req_t;

	typedef enum logic [2:0] {
		CL_IDLE,
		CL_LOAD,
		CL_GET,
		CL_SCAN,
		CL_WB,
		CL_DONE
	} clo_state_t;

	typedef enum logic {
		TS_CLEAR,
		TS_RUN
	} top_state_t;

endpackage

// ===== rtl/lrc_row_ram.sv =====
`timescale 1ns / 1ps

module lrc_row_ram (
	input  logic             clk,
	input  lrc_pkg::mem_req_t req,
	output lrc_pkg::row_t    rdata
);

	lrc_pkg::row_t mem [lrc_pkg::NUM_TYPES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== rtl/lrc_closure_eng.sv =====
`timescale 1ns / 1ps

module lrc_closure_eng (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              ack,
	input  lrc_pkg::row_t     rdata,
	output lrc_pkg::mem_req_t req,
	output logic              done
);

	localparam logic [lrc_pkg::TYPE_W:0] JEND =
		(lrc_pkg::TYPE_W + 1)'(lrc_pkg::NUM_TYPES);
	localparam lrc_pkg::row_addr_t ILAST =
		lrc_pkg::TYPE_W'(lrc_pkg::NUM_TYPES - 1);

	lrc_pkg::clo_state_t state_q, state_d;
	lrc_pkg::row_addr_t  i_q, i_d;
	logic [lrc_pkg::TYPE_W:0] j_q, j_d;
	lrc_pkg::row_addr_t  jd_s1, jd_d;
	lrc_pkg::row_t       row_q, row_d;
	logic                changed_q, changed_d;
	lrc_pkg::label_t     x;
	lrc_pkg::row_t       add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lrc_pkg::CL_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			jd_s1     <= '0;
			changed_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			i_q       <= i_d;
			j_q       <= j_d;
			jd_s1     <= jd_d;
			changed_q <= changed_d;
		end
	end

	always_ff @(posedge clk) begin
		row_q <= row_d;
	end

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		j_d       = j_q;
		jd_d      = jd_s1;
		row_d     = row_q;
		changed_d = changed_q;
		req       = '0;
		done      = 1'b0;
		x         = row_q[jd_s1];
		add       = rdata & {lrc_pkg::NUM_TYPES{x}};
		unique case (state_q)
			lrc_pkg::CL_IDLE: begin
				if (start) begin
					i_d       = '0;
					changed_d = 1'b0;
					state_d   = lrc_pkg::CL_LOAD;
				end
			end
			lrc_pkg::CL_LOAD: begin
				req.re    = 1'b1;
				req.raddr = i_q;
				state_d   = lrc_pkg::CL_GET;
			end
			lrc_pkg::CL_GET: begin
				row_d     = rdata;
				req.re    = 1'b1;
				req.raddr = '0;
				jd_d      = '0;
				j_d       = (lrc_pkg::TYPE_W + 1)'(1);
				state_d   = lrc_pkg::CL_SCAN;
			end
			lrc_pkg::CL_SCAN: begin
				// fold row j, scaled by label (i,j), into row i
				row_d = row_q | add;
				if (|(add & ~row_q)) begin
					changed_d = 1'b1;
				end
				if (j_q == JEND) begin
					state_d = lrc_pkg::CL_WB;
				end else begin
					req.re    = 1'b1;
					req.raddr = j_q[lrc_pkg::TYPE_W-1:0];
					jd_d      = j_q[lrc_pkg::TYPE_W-1:0];
					j_d       = j_q + 1'b1;
				end
			end
			lrc_pkg::CL_WB: begin
				req.we    = 1'b1;
				req.waddr = i_q;
				req.wdata = row_q;
				if (i_q == ILAST) begin
					if (changed_q) begin
						i_d       = '0;
						changed_d = 1'b0;
						state_d   = lrc_pkg::CL_LOAD;
					end else begin
						state_d = lrc_pkg::CL_DONE;
					end
				end else begin
					i_d     = i_q + 1'b1;
					state_d = lrc_pkg::CL_LOAD;
				end
			end
			lrc_pkg::CL_DONE: begin
				done = 1'b1;
				if (ack) begin
					state_d = lrc_pkg::CL_IDLE;
				end
			end
			default: begin
				state_d = lrc_pkg::CL_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/labeled_relation_closure_unit.sv =====
`timescale 1ns / 1ps

// Relation table of 4-bit labels between type codes, held one row per word in a
// synchronous RAM (NUM_TYPES rows of NUM_TYPES labels). After reset a clearing
// pass writes every row to zero, one row a cycle, and in_stall stays high until
// it is done. Write and query items then go at one item per cycle while the
// output is free: the row is read in the cycle the item is taken and modified
// or tested in the next, with the last written row forwarded around the RAM.
// A query item's result is registered from the s1 stage into the output register
// once the output is free; a write item gives none, and neither does an unused
// command. A closure item holds the input while, for each row i, the engine
// loads row i, streams all rows j through the single read port and writes row i
// back, in passes repeated until a pass changes no entry; then one item with
// closure_done set and kill clear comes out.
module labeled_relation_closure_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic [lrc_pkg::FIELD_W-1:0]        from_type,
	input  logic [lrc_pkg::FIELD_W-1:0]        to_type,
	input  logic [lrc_pkg::LABEL_W-1:0]        write_mask,
	input  logic [lrc_pkg::LABEL_W-1:0]        write_bits,
	input  logic signed [lrc_pkg::KIND_W-1:0]  query_kind,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kill,
	output logic                               closure_done
);

	localparam lrc_pkg::row_addr_t CLR_LAST = lrc_pkg::TYPE_W'(lrc_pkg::NUM_TYPES - 1);
	localparam logic [lrc_pkg::FIELD_W:0] TYPE_END =
		(lrc_pkg::FIELD_W + 1)'(lrc_pkg::NUM_TYPES);

	function automatic lrc_pkg::label_t test_mask(input logic [lrc_pkg::KIND_W-1:0] mag);
		lrc_pkg::label_t m;
		unique case (mag)
			3'd0:    m = lrc_pkg::EXACT_MASK;
			3'd1:    m = 4'b0010;
			3'd2:    m = 4'b0100;
			3'd3:    m = 4'b1000;
			default: m = 4'b0000;
		endcase
		return m;
	endfunction

	lrc_pkg::top_state_t state_q, state_d;
	lrc_pkg::row_addr_t  clr_q;

	lrc_pkg::cmd_t                  in_cmd;
	logic [lrc_pkg::KIND_W-1:0]     kraw;
	logic [lrc_pkg::KIND_W-1:0]     mag;
	logic                           swap;
	logic [lrc_pkg::FIELD_W-1:0]    row_sel;
	logic [lrc_pkg::FIELD_W-1:0]    col_sel;
	logic                           in_range;
	logic                           accept;

	logic                s1_valid_q;
	lrc_pkg::cmd_t       cmd_s1;
	lrc_pkg::row_addr_t  row_s1;
	lrc_pkg::row_addr_t  col_s1;
	lrc_pkg::label_t     mask_s1;
	lrc_pkg::label_t     bits_s1;
	lrc_pkg::label_t     tmask_s1;
	logic                inr_s1;

	logic                lastw_v_q;
	lrc_pkg::row_addr_t  lastw_row_q;
	lrc_pkg::row_t       lastw_data_q;

	lrc_pkg::mem_req_t   mem_req;
	lrc_pkg::mem_req_t   eng_req;
	lrc_pkg::row_t       rdata;
	lrc_pkg::row_t       row_data;
	lrc_pkg::row_t       new_row;
	lrc_pkg::label_t     label;

	logic out_valid_q;
	logic kill_q;
	logic done_q;
	logic out_free;
	logic is_write;
	logic is_close;
	logic is_query;
	logic s1_adv;
	logic out_load;
	logic eng_start;
	logic eng_ack;
	logic eng_done;

	assign out_valid    = out_valid_q;
	assign kill         = kill_q;
	assign closure_done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrc_pkg::TS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lrc_pkg::TS_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrc_pkg::TS_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = lrc_pkg::TS_RUN;
				end
			end
			lrc_pkg::TS_RUN: begin
				state_d = lrc_pkg::TS_RUN;
			end
			default: begin
				state_d = lrc_pkg::TS_CLEAR;
			end
		endcase
	end

	assign in_cmd  = lrc_pkg::cmd_t'(cmd);
	assign kraw    = query_kind;
	assign mag     = kraw[lrc_pkg::KIND_W-1] ? (lrc_pkg::KIND_W'(0) - kraw) : kraw;
	assign swap    = (in_cmd == lrc_pkg::CMD_QUERY) && kraw[lrc_pkg::KIND_W-1];
	assign row_sel = swap ? to_type : from_type;
	assign col_sel = swap ? from_type : to_type;
	assign in_range = ({1'b0, row_sel} < TYPE_END) && ({1'b0, col_sel} < TYPE_END);

	assign is_write = (cmd_s1 == lrc_pkg::CMD_WRITE);
	assign is_close = (cmd_s1 == lrc_pkg::CMD_CLOSE);
	assign is_query = (cmd_s1 == lrc_pkg::CMD_QUERY);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		s1_adv = 1'b1;
		if (s1_valid_q) begin
			if (is_query) begin
				s1_adv = out_free;
			end else if (is_close) begin
				s1_adv = eng_done && out_free;
			end
		end
	end

	assign in_stall  = (state_q != lrc_pkg::TS_RUN) || !s1_adv;
	assign accept    = in_valid && !in_stall;
	assign out_load  = s1_valid_q && s1_adv && (is_query || is_close);
	assign eng_start = s1_valid_q && is_close;
	assign eng_ack   = eng_start && eng_done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= in_cmd;
			row_s1   <= row_sel[lrc_pkg::TYPE_W-1:0];
			col_s1   <= col_sel[lrc_pkg::TYPE_W-1:0];
			mask_s1  <= write_mask;
			bits_s1  <= write_bits;
			tmask_s1 <= test_mask(mag);
			inr_s1   <= in_range;
		end
	end

	always_comb begin
		row_data = (lastw_v_q && (lastw_row_q == row_s1)) ? lastw_data_q : rdata;
		label    = row_data[col_s1];
		new_row  = row_data;
		new_row[col_s1] = (label & ~mask_s1) | (bits_s1 & mask_s1);
	end

	always_comb begin
		mem_req = '0;
		if (state_q == lrc_pkg::TS_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = clr_q;
		end else if (eng_start && !eng_done) begin
			mem_req = eng_req;
		end else begin
			mem_req.re    = accept;
			mem_req.raddr = row_sel[lrc_pkg::TYPE_W-1:0];
			mem_req.we    = s1_valid_q && is_write && inr_s1;
			mem_req.waddr = row_s1;
			mem_req.wdata = new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastw_v_q <= 1'b0;
		end else if (mem_req.we) begin
			lastw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			lastw_row_q  <= mem_req.waddr;
			lastw_data_q <= mem_req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kill_q <= is_query && (!inr_s1 || ((label & tmask_s1) == '0));
			done_q <= is_close;
		end
	end

	lrc_row_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	lrc_closure_eng u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.ack    (eng_ack),
		.rdata  (rdata),
		.req    (eng_req),
		.done   (eng_done)
	);

endmodule

// ===== rtl/lrc_checker.sv =====
`timescale 1ns / 1ps

`include "labeled_relation_closure_unit_assert.svh"

module lrc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] cmd,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kill,
	input logic       closure_done
);

	`LRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kill) && $stable(closure_done), "result item changed while stalled")
	`LRC_ASSERT_NOW(a_done_no_kill, out_valid && closure_done, !kill, "closure result carries kill")
	`LRC_ASSERT_NEXT(a_close_holds, in_valid && !in_stall && (cmd == lrc_pkg::CMD_CLOSE), in_stall, "input taken right after a closure item")

endmodule

bind labeled_relation_closure_unit lrc_checker u_lrc_checker (.*);

// ===== test/tb_labeled_relation_closure_unit.sv =====
`timescale 1ns / 1ps

module tb_labeled_relation_closure_unit;

	typedef struct {
		bit kill_flag;
		bit done_flag;
	} answer_t;

	class relation_mirror;
		lrc_pkg::label_t labels [lrc_pkg::NUM_TYPES][lrc_pkg::NUM_TYPES];
		answer_t         awaiting [$];
		int unsigned     errors;

		function new();
			foreach (labels[i, j])
				labels[i][j] = '0;
			errors = 0;
		endfunction

		function void close_table();
			bit              changed;
			lrc_pkg::label_t x;
			lrc_pkg::label_t y;
			do begin
				changed = 0;
				for (int i = 0; i < lrc_pkg::NUM_TYPES; i++) begin
					for (int j = 0; j < lrc_pkg::NUM_TYPES; j++) begin
						x = labels[i][j];
						if (x != '0) begin
							for (int k = 0; k < lrc_pkg::NUM_TYPES; k++) begin
								y = labels[j][k] & x;
								if ((labels[i][k] | y) != labels[i][k]) begin
									labels[i][k] = labels[i][k] | y;
									changed = 1;
								end
							end
						end
					end
				end
			end while (changed);
		endfunction

		function void absorb_item(lrc_pkg::cmd_t op, logic [lrc_pkg::FIELD_W-1:0] src,
				logic [lrc_pkg::FIELD_W-1:0] dst, lrc_pkg::label_t mask,
				lrc_pkg::label_t bits, logic signed [lrc_pkg::KIND_W-1:0] kind);
			logic [lrc_pkg::FIELD_W-1:0] r;
			logic [lrc_pkg::FIELD_W-1:0] c;
			int                          mag;
			logic [lrc_pkg::LABEL_W:0]   probe;
			lrc_pkg::label_t             lab;
			answer_t                     ans;
			case (op)
				lrc_pkg::CMD_WRITE: begin
					if (src < lrc_pkg::NUM_TYPES && dst < lrc_pkg::NUM_TYPES)
						labels[src][dst] = (labels[src][dst] & ~mask) | (bits & mask);
				end
				lrc_pkg::CMD_CLOSE: begin
					close_table();
					ans.kill_flag = 1'b0;
					ans.done_flag = 1'b1;
					awaiting.push_back(ans);
				end
				lrc_pkg::CMD_QUERY: begin
					r = src;
					c = dst;
					mag = kind;
					// swap types on a negative kind
					if (kind < 0) begin
						r = dst;
						c = src;
						mag = -mag;
					end
					lab = (r < lrc_pkg::NUM_TYPES && c < lrc_pkg::NUM_TYPES) ?
						labels[r][c] : '0;
					probe = (mag == 0) ? {1'b0, lrc_pkg::EXACT_MASK} :
						(lrc_pkg::LABEL_W + 1)'(1 << mag);
					ans.kill_flag = (({1'b0, lab} & probe) == '0);
					ans.done_flag = 1'b0;
					awaiting.push_back(ans);
				end
				default: ;
			endcase
		endfunction

		function void match_answer(logic got_kill, logic got_done);
			answer_t want;
			if (awaiting.size() == 0) begin
				$display("%0t: unexpected item kill %0b closure_done %0b",
					$time, got_kill, got_done);
				errors++;
			end else begin
				want = awaiting.pop_front();
				if (got_kill !== want.kill_flag) begin
					$display("%0t: kill expected %0b got %0b", $time, want.kill_flag, got_kill);
					errors++;
				end
				if (got_done !== want.done_flag) begin
					$display("%0t: closure_done expected %0b got %0b",
						$time, want.done_flag, got_done);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return awaiting.size();
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	lrc_pkg::cmd_t                       cmd;
	logic [lrc_pkg::FIELD_W-1:0]         from_type;
	logic [lrc_pkg::FIELD_W-1:0]         to_type;
	logic [lrc_pkg::LABEL_W-1:0]         write_mask;
	logic [lrc_pkg::LABEL_W-1:0]         write_bits;
	logic signed [lrc_pkg::KIND_W-1:0]   query_kind;
	logic                                out_valid;
	logic                                out_stall;
	logic                                kill;
	logic                                closure_done;

	logic                                calm;
	int                                  items_taken = 0;
	bit                                  squeezed;

	relation_mirror shadow = new();

	labeled_relation_closure_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.from_type    (from_type),
		.to_type      (to_type),
		.write_mask   (write_mask),
		.write_bits   (write_bits),
		.query_kind   (query_kind),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kill         (kill),
		.closure_done (closure_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#150_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				shadow.absorb_item(cmd, from_type, to_type, write_mask, write_bits, query_kind);
				items_taken++;
			end
			if (out_valid === 1'b1 && out_stall === 1'b0)
				shadow.match_answer(kill, closure_done);
		end
	end

	initial begin
		out_stall = 1'b0;
		squeezed = 0;
		forever begin
			@(negedge clk);
			if (!squeezed && items_taken >= 1200) begin
				// hold the output long enough to back up the input
				squeezed = 1;
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 14);
			end
		end
	end

	task automatic send_item(lrc_pkg::cmd_t op, logic [lrc_pkg::FIELD_W-1:0] src,
			logic [lrc_pkg::FIELD_W-1:0] dst,
			logic [lrc_pkg::LABEL_W-1:0] mask, logic [lrc_pkg::LABEL_W-1:0] bits,
			logic signed [lrc_pkg::KIND_W-1:0] kind);
		while (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		from_type  <= src;
		to_type    <= dst;
		write_mask <= mask;
		write_bits <= bits;
		query_kind <= kind;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [lrc_pkg::FIELD_W-1:0] pick_type(bit wide);
		return wide ? lrc_pkg::FIELD_W'($urandom_range(lrc_pkg::NUM_TYPES - 1)) :
			lrc_pkg::FIELD_W'($urandom_range(7));
	endfunction

	function automatic logic [lrc_pkg::LABEL_W-1:0] pick_label();
		return lrc_pkg::LABEL_W'($urandom_range(15));
	endfunction

	function automatic logic signed [lrc_pkg::KIND_W-1:0] pick_kind();
		return lrc_pkg::KIND_W'($urandom_range(7));
	endfunction

	initial begin
		int roll;
		bit wide;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		cmd         = lrc_pkg::CMD_WRITE;
		from_type   = '0;
		to_type     = '0;
		write_mask  = '0;
		write_bits  = '0;
		query_kind  = '0;
		calm        = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(lrc_pkg::CMD_WRITE, 0, 0, 4'hF, 4'hF, 0);
		send_item(lrc_pkg::CMD_WRITE, 127, 127, 4'hF, 4'hF, 3);
		send_item(lrc_pkg::CMD_WRITE, 0, 127, 4'h0, 4'hF, -4);
		send_item(lrc_pkg::CMD_WRITE, 1, 1, 4'hF, 4'h0, 0);
		send_item(lrc_pkg::CMD_WRITE, 127, 0, 4'h5, 4'hF, 0);
		send_item(lrc_pkg::CMD_WRITE, 127, 0, 4'hA, 4'h5, 0);
		for (int k = -4; k <= 3; k++)
			send_item(lrc_pkg::CMD_QUERY, 0, 0, 4'h0, 4'h0, k[lrc_pkg::KIND_W-1:0]);
		send_item(lrc_pkg::CMD_QUERY, 127, 0, 4'hF, 4'hF, 0);
		send_item(lrc_pkg::CMD_QUERY, 0, 127, 4'h0, 4'h0, -1);
		send_item(lrc_pkg::CMD_QUERY, 0, 127, 4'h0, 4'h0, -2);
		send_item(lrc_pkg::CMD_QUERY, 1, 1, 4'h0, 4'h0, 0);
		send_item(lrc_pkg::CMD_QUERY, 5, 9, 4'h0, 4'h0, 3);
		send_item(lrc_pkg::CMD_NONE, 127, 127, 4'hF, 4'hF, -1);
		send_item(lrc_pkg::CMD_WRITE, 1, 2, 4'hF, 4'h2, 0);
		send_item(lrc_pkg::CMD_WRITE, 2, 3, 4'hF, 4'h6, 0);
		send_item(lrc_pkg::CMD_CLOSE, 0, 0, 4'h0, 4'h0, 0);
		send_item(lrc_pkg::CMD_QUERY, 1, 3, 4'h0, 4'h0, 1);
		send_item(lrc_pkg::CMD_QUERY, 3, 1, 4'h0, 4'h0, -2);

		for (int n = 0; n < 1900; n++) begin
			calm <= (n >= 700 && n < 1000);
			roll = $urandom_range(99);
			if (n % 380 == 190) begin
				send_item(lrc_pkg::CMD_CLOSE, pick_type(1), pick_type(1), pick_label(),
					pick_label(), pick_kind());
			end else if (roll < 45) begin
				wide = ($urandom_range(99) < 15);
				send_item(lrc_pkg::CMD_WRITE, pick_type(wide), pick_type(wide), pick_label(),
					pick_label(), pick_kind());
			end else if (roll < 96) begin
				wide = ($urandom_range(99) < 30);
				send_item(lrc_pkg::CMD_QUERY, pick_type(wide), pick_type(wide), pick_label(),
					pick_label(), pick_kind());
			end else begin
				send_item(lrc_pkg::CMD_NONE, pick_type(1), pick_type(1), pick_label(),
					pick_label(), pick_kind());
			end
		end
		in_valid <= 1'b0;
		calm     <= 1'b0;

		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (shadow.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lrc_pkg.sv
rtl/lrc_row_ram.sv
rtl/lrc_closure_eng.sv
rtl/labeled_relation_closure_unit.sv
rtl/lrc_checker.sv
test/tb_labeled_relation_closure_unit.sv
